>>> src/touch_report_scanner_unit_assert.svh
`ifndef TOUCH_REPORT_SCANNER_UNIT_ASSERT_SVH
`define TOUCH_REPORT_SCANNER_UNIT_ASSERT_SVH

// next-cycle check, masked while in reset
`define TRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

// next-cycle check that also runs during reset
`define TRS_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> src/trs_pkg.sv
`timescale 1ns / 1ps
package trs_pkg;

  localparam int NUM_SLOTS       = 5;
  localparam int POLL_DIVIDE_DEF = 10;
  localparam int POLL_LIMIT      = 240;
  localparam int QDEPTH          = 2;
  localparam int SLOT_W          = $clog2(NUM_SLOTS);
  localparam int CFG_IDX_W       = 2;

  localparam logic [15:0] ORIGIN_A    = 16'd320;
  localparam logic [15:0] ORIGIN_B    = 16'd480;
  localparam logic [15:0] PANEL_W_RST = 16'd320;
  localparam logic [15:0] PANEL_H_RST = 16'd480;
  localparam logic [15:0] POS_NONE    = 16'hFFFF;

  localparam logic [7:0] FLAG_PRESSED  = 8'h80;
  localparam logic [7:0] FLAG_CAPTURED = 8'h40;
  localparam logic [7:0] MODE_RELEASE  = 8'h80;
  localparam logic [7:0] MODE_REL_MASK = 8'h8F;
  localparam logic [7:0] KEEP_PRESS    = 8'h7F;
  localparam logic [7:0] KEEP_HIGH     = 8'hE0;
  localparam logic [3:0] CNT_LIMIT     = 4'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_DIR     = 2'd0,
    REG_PANEL_WIDTH  = 2'd1,
    REG_PANEL_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_U2D_L2R = 2'd0,
    DIR_R2L_U2D = 2'd1,
    DIR_L2R_D2U = 2'd2,
    DIR_OTHER   = 2'd3
  } scan_dir_t;

  typedef logic [NUM_SLOTS-1:0][15:0] coord_arr_t;

  typedef struct packed {
    coord_arr_t  x;
    coord_arr_t  y;
    logic [7:0]  flags;
    logic        new_data;
    logic        clear_request;
  } scan_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> src/trs_front.sv
`timescale 1ns / 1ps
module trs_front #(
  parameter int POLL_DIVIDE = trs_pkg::POLL_DIVIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [trs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          accept,
  input  logic [7:0]                    status_byte,
  input  logic [7:0]                    mode_in,
  input  trs_pkg::coord_arr_t           raw_a,
  input  trs_pkg::coord_arr_t           raw_b,
  output trs_pkg::scan_rec_t            rec
);
  import trs_pkg::*;

  localparam int MOD_W = $clog2(POLL_DIVIDE);

  logic [1:0]       dir_r;
  logic [15:0]      panel_w_r, panel_h_r;
  logic [7:0]       poll_r, poll_nxt;
  logic [MOD_W-1:0] mod_r, mod_nxt;
  logic [7:0]       flags_r, flags_nxt;
  coord_arr_t       x_r, y_r, x_nxt, y_nxt;
  coord_arr_t       map_x, map_y;

  logic [7:0]       pc_inc;
  logic [MOD_W-1:0] mod_inc;
  logic             sample;
  logic [7:0]       mode;
  logic [3:0]       cnt;
  logic             newd, clr;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      unique case (scan_dir_t'(dir_r))
        DIR_U2D_L2R: begin
          map_y[i] = ORIGIN_A - raw_a[i];
          map_x[i] = raw_b[i];
        end
        DIR_R2L_U2D: begin
          map_x[i] = raw_a[i];
          map_y[i] = raw_b[i];
        end
        DIR_L2R_D2U: begin
          map_x[i] = ORIGIN_A - raw_a[i];
          map_y[i] = ORIGIN_B - raw_b[i];
        end
        DIR_OTHER: begin
          map_y[i] = raw_a[i];
          map_x[i] = ORIGIN_B - raw_b[i];
        end
      endcase
    end
  end

  // mod_r tracks poll_r modulo the divider
  always_comb begin
    pc_inc  = poll_r + 8'd1;
    mod_inc = (mod_r == MOD_W'(POLL_DIVIDE - 1)) ? '0 : mod_r + MOD_W'(1);
    sample  = (mod_inc == '0) || (pc_inc < 8'(POLL_DIVIDE));
    mode      = mode_in;
    cnt       = status_byte[3:0];
    newd      = 1'b0;
    clr       = 1'b0;
    flags_nxt = flags_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    poll_nxt  = pc_inc;
    mod_nxt   = mod_inc;
    if (sample) begin
      mode = status_byte;
      if (mode[7] && cnt < CNT_LIMIT) clr = 1'b1;
      if (cnt != 4'd0 && cnt < CNT_LIMIT) begin
        flags_nxt = ~(8'hFF << cnt) | FLAG_PRESSED | FLAG_CAPTURED;
        x_nxt[NUM_SLOTS-1] = x_r[0];
        y_nxt[NUM_SLOTS-1] = y_r[0];
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (flags_nxt[i]) begin
            x_nxt[i] = map_x[i];
            y_nxt[i] = map_y[i];
          end
        end
        newd = 1'b1;
        if (x_nxt[0] > panel_w_r || y_nxt[0] > panel_h_r) begin
          if (cnt > 4'd1) begin
            x_nxt[0] = x_nxt[1];
            y_nxt[0] = y_nxt[1];
            poll_nxt = '0;
            mod_nxt  = '0;
          end else begin
            x_nxt[0]  = x_nxt[NUM_SLOTS-1];
            y_nxt[0]  = y_nxt[NUM_SLOTS-1];
            mode      = MODE_RELEASE;
            flags_nxt = flags_r;
          end
        end else begin
          poll_nxt = '0;
          mod_nxt  = '0;
        end
      end
    end
    if ((mode & MODE_REL_MASK) == MODE_RELEASE) begin
      if ((flags_nxt & FLAG_PRESSED) != 8'd0) begin
        flags_nxt = flags_nxt & KEEP_PRESS;
      end else begin
        x_nxt[0]  = POS_NONE;
        y_nxt[0]  = POS_NONE;
        flags_nxt = flags_nxt & KEEP_HIGH;
      end
    end
    if (poll_nxt > 8'(POLL_LIMIT)) begin
      poll_nxt = 8'(POLL_DIVIDE);
      mod_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r     <= DIR_U2D_L2R;
      panel_w_r <= PANEL_W_RST;
      panel_h_r <= PANEL_H_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCAN_DIR:     dir_r     <= cfg_data[1:0];
        REG_PANEL_WIDTH:  panel_w_r <= cfg_data;
        REG_PANEL_HEIGHT: panel_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_r  <= '0;
      mod_r   <= '0;
      flags_r <= '0;
      x_r     <= '0;
      y_r     <= '0;
    end else if (accept) begin
      poll_r  <= poll_nxt;
      mod_r   <= mod_nxt;
      flags_r <= flags_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
    end
  end

  assign rec.x             = x_nxt;
  assign rec.y             = y_nxt;
  assign rec.flags         = flags_nxt;
  assign rec.new_data      = newd;
  assign rec.clear_request = clr;

endmodule

>>> src/trs_queue.sv
`timescale 1ns / 1ps
module trs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  trs_pkg::scan_rec_t wr_rec,
  input  logic               rd_en,
  output trs_pkg::scan_rec_t rd_rec,
  output trs_pkg::q_stat_t   stat
);
  import trs_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  scan_rec_t        mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign stat.full  = (count_r == CNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_rec     = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) count_nxt = count_r + CNT_W'(1);
    else if (!wr_en && rd_en) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (rd_en) rd_ptr_r <= ptr_inc(rd_ptr_r);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_rec;
  end

endmodule

>>> src/trs_back.sv
`timescale 1ns / 1ps
module trs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  trs_pkg::scan_rec_t         q_rec,
  input  trs_pkg::q_stat_t           q_stat,
  output logic                       q_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic [trs_pkg::SLOT_W-1:0] out_slot,
  output logic [15:0]                out_pos_x,
  output logic [15:0]                out_pos_y,
  output logic [7:0]                 out_touch_flags,
  output logic                       out_new_data,
  output logic                       out_clear_request,
  output logic                       out_last
);
  import trs_pkg::*;

  scan_rec_t         rec_r;
  logic              busy_r, busy_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              is_last, take;

  assign is_last = (slot_r == SLOT_W'(NUM_SLOTS - 1));
  assign take    = !busy_r || (pop && is_last);
  assign q_pop   = take && !q_stat.empty;

  always_comb begin
    busy_nxt = busy_r;
    slot_nxt = slot_r;
    if (take) begin
      busy_nxt = !q_stat.empty;
      slot_nxt = '0;
    end else if (pop) begin
      slot_nxt = slot_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) rec_r <= q_rec;
  end

  assign empty             = !busy_r;
  assign out_slot          = slot_r;
  assign out_pos_x         = rec_r.x[slot_r];
  assign out_pos_y         = rec_r.y[slot_r];
  assign out_touch_flags   = rec_r.flags;
  assign out_new_data      = rec_r.new_data;
  assign out_clear_request = rec_r.clear_request;
  assign out_last          = is_last;

endmodule

>>> src/touch_report_scanner_unit.sv
`timescale 1ns / 1ps
// With the back end idle, slot 0 of a scan reaches the result ports once the scan is written into
// the queue and then moved from the queue into the result register.
// Throughput: one slot result per cycle through the result register while pop is asserted.
// Front computes a whole scan combinationally; a two-entry queue decouples it from the back.
// Reset: synchronous active-low rst_n; poll, flags and slot coordinates clear, config
// registers return to scan_dir 0, width 320, height 480, and the queue empties.
module touch_report_scanner_unit #(
  parameter int POLL_DIVIDE = trs_pkg::POLL_DIVIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [trs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_status_byte,
  input  logic [7:0]                    in_mode_in,
  input  logic [15:0]                   in_raw_a_p0,
  input  logic [15:0]                   in_raw_b_p0,
  input  logic [15:0]                   in_raw_a_p1,
  input  logic [15:0]                   in_raw_b_p1,
  input  logic [15:0]                   in_raw_a_p2,
  input  logic [15:0]                   in_raw_b_p2,
  input  logic [15:0]                   in_raw_a_p3,
  input  logic [15:0]                   in_raw_b_p3,
  input  logic [15:0]                   in_raw_a_p4,
  input  logic [15:0]                   in_raw_b_p4,
  output logic                          empty,
  input  logic                          pop,
  output logic [trs_pkg::SLOT_W-1:0]    out_slot,
  output logic [15:0]                   out_pos_x,
  output logic [15:0]                   out_pos_y,
  output logic [7:0]                    out_touch_flags,
  output logic                          out_new_data,
  output logic                          out_clear_request,
  output logic                          out_last
);
  import trs_pkg::*;

  coord_arr_t raw_a, raw_b;
  scan_rec_t  front_rec, q_rec;
  q_stat_t    q_stat;
  logic       accept, q_pop;

  assign raw_a = {in_raw_a_p4, in_raw_a_p3, in_raw_a_p2, in_raw_a_p1, in_raw_a_p0};
  assign raw_b = {in_raw_b_p4, in_raw_b_p3, in_raw_b_p2, in_raw_b_p1, in_raw_b_p0};

  assign cfg_ready = 1'b1;
  assign full      = q_stat.full;
  assign accept    = push && !q_stat.full;

  trs_front #(.POLL_DIVIDE(POLL_DIVIDE)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .status_byte (in_status_byte),
    .mode_in     (in_mode_in),
    .raw_a       (raw_a),
    .raw_b       (raw_b),
    .rec         (front_rec)
  );

  trs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (accept),
    .wr_rec (front_rec),
    .rd_en  (q_pop),
    .rd_rec (q_rec),
    .stat   (q_stat)
  );

  trs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_rec             (q_rec),
    .q_stat            (q_stat),
    .q_pop             (q_pop),
    .pop               (pop),
    .empty             (empty),
    .out_slot          (out_slot),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_touch_flags   (out_touch_flags),
    .out_new_data      (out_new_data),
    .out_clear_request (out_clear_request),
    .out_last          (out_last)
  );

endmodule

>>> src/trs_checker.sv
`timescale 1ns / 1ps
`include "touch_report_scanner_unit_assert.svh"
module trs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       empty,
  input logic                       pop,
  input logic [trs_pkg::SLOT_W-1:0] out_slot,
  input logic [7:0]                 out_touch_flags,
  input logic                       out_new_data,
  input logic                       out_last
);
  import trs_pkg::*;

  logic              adv;
  logic [SLOT_W-1:0] slot_succ;

  assign adv       = !empty && pop && !out_last;
  assign slot_succ = out_slot + SLOT_W'(1);

  // slots of one scan follow each other without a gap
  `TRS_ASSERT_NEXT(a_slot_seq, clk, rst_n, adv, !empty && out_slot == $past(slot_succ))

  // scan-wide fields stay fixed across the slots of one scan
  `TRS_ASSERT_NEXT(a_scan_fields, clk, rst_n, adv, $stable(out_touch_flags) && $stable(out_new_data))

  // a stalled result holds
  `TRS_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_slot))

  // nothing left to deliver after reset
  `TRS_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, !rst_n, empty)

endmodule

bind touch_report_scanner_unit trs_checker u_trs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .empty           (empty),
  .pop             (pop),
  .out_slot        (out_slot),
  .out_touch_flags (out_touch_flags),
  .out_new_data    (out_new_data),
  .out_last        (out_last)
);
